@@ hw/rtl/envelope_beat_detector_assert.svh @@
// Assertion macros shared by the envelope beat detector checkers
`ifndef ENVELOPE_BEAT_DETECTOR_ASSERT_SVH
`define ENVELOPE_BEAT_DETECTOR_ASSERT_SVH

// same-cycle implication, switched off while reset is high
`define EBD_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, switched off while reset is high
`define EBD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// next-cycle implication that also holds across reset
`define EBD_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

@@ hw/rtl/ebd_pkg.sv @@
// Shared constants and types of the envelope beat detector
`default_nettype none

package ebd_pkg;

   localparam int FRAC_BITS    = 16;
   localparam int CFG_BITS     = 16;
   localparam int LEVEL_BITS   = 16;
   localparam int CSR_IDX_BITS = 4;

   localparam logic [CSR_IDX_BITS-1:0] CSR_RISE_THRESHOLD = 4'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_FALL_THRESHOLD = 4'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SLOW_WEIGHT    = 4'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_FAST_WEIGHT    = 4'd3;

   localparam logic [CFG_BITS-1:0] RISE_THRESHOLD_RESET = 16'd328;
   localparam logic [CFG_BITS-1:0] FALL_THRESHOLD_RESET = 16'd328;
   localparam logic [CFG_BITS-1:0] SLOW_WEIGHT_RESET    = 16'd7;
   localparam logic [CFG_BITS-1:0] FAST_WEIGHT_RESET    = 16'd19661;

   localparam logic [LEVEL_BITS-1:0] LEVEL_MAX = 16'hFFFF;

   typedef struct packed {
      logic                  beat;
      logic                  raise;
      logic [LEVEL_BITS-1:0] fast_level;
      logic [LEVEL_BITS-1:0] slow_level;
   } decision_type;

endpackage

`default_nettype wire

@@ hw/rtl/ebd_ifs.sv @@
// Channel interfaces of the envelope beat detector: sample, result and register write
`default_nettype none

interface ebd_req_if #(parameter int SAMPLE_BITS = 16) ();
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample;
   logic                          last_in_block;

   modport source (output valid, sample, last_in_block, input ready);
   modport sink   (input valid, sample, last_in_block, output ready);
endinterface

interface ebd_rsp_if import ebd_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic                  beat;
   logic [LEVEL_BITS-1:0] fast_level;
   logic [LEVEL_BITS-1:0] slow_level;

   modport source (output valid, beat, fast_level, slow_level, input ready);
   modport sink   (input valid, beat, fast_level, slow_level, output ready);
endinterface

interface ebd_csr_if import ebd_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [CSR_IDX_BITS-1:0] index;
   logic [CFG_BITS-1:0]     data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/ebd_follower.sv @@
// One exponential envelope step in 16.16 fixed point
`default_nettype none

module ebd_follower import ebd_pkg::*; #(
   parameter int LW = 32
) (
   input  logic [LW-1:0]       level,
   input  logic [LW-1:0]       target,
   input  logic [CFG_BITS-1:0] weight,
   output logic [LW-1:0]       level_next
);

   localparam int PW = LW + CFG_BITS;

   logic          up;
   logic [LW-1:0] diff;
   logic [PW-1:0] prod;
   logic [PW-1:0] prod_rnd;

   assign up   = target >= level;
   assign diff = up ? (target - level) : (level - target);
   assign prod = PW'(diff) * PW'(weight);
   // falling: round the step up so the whole update floors
   assign prod_rnd = prod + PW'({FRAC_BITS{1'b1}});

   assign level_next = up ? (level + LW'(prod >> FRAC_BITS))
                          : (level - LW'(prod_rnd >> FRAC_BITS));

endmodule

`default_nettype wire

@@ hw/rtl/ebd_decide.sv @@
// End-of-block beat decision with hysteresis, slow raise and level saturation
`default_nettype none

module ebd_decide import ebd_pkg::*; #(
   parameter int LW = 32
) (
   input  logic                beat,
   input  logic [LW-1:0]       fast_env,
   input  logic [LW-1:0]       slow_env,
   input  logic [CFG_BITS-1:0] rise_threshold,
   input  logic [CFG_BITS-1:0] fall_threshold,
   output decision_type        decision
);

   localparam int IW = LW - FRAC_BITS;
   localparam int CW = (IW > LEVEL_BITS) ? IW : LEVEL_BITS;

   logic          fast_gt;
   logic          fast_lt;
   logic          slow_frac_nz;
   logic [CW-1:0] slow_cw;
   logic [CW-1:0] fast_cw;
   logic [CW-1:0] rise_cw;
   logic [CW-1:0] fall_cw;
   logic [CW-1:0] slow_out_cw;
   logic          above_rise;
   logic          below_fall;
   logic          beat_next;

   assign fast_gt      = fast_env > slow_env;
   assign fast_lt      = fast_env < slow_env;
   assign slow_frac_nz = |slow_env[FRAC_BITS-1:0];
   assign slow_cw      = CW'(slow_env[LW-1:FRAC_BITS]);
   assign fast_cw      = CW'(fast_env[LW-1:FRAC_BITS]);
   assign rise_cw      = CW'(rise_threshold);
   assign fall_cw      = CW'(fall_threshold);

   // thresholds sit at threshold.0, so only the fraction breaks a tie
   assign above_rise = (slow_cw > rise_cw) || ((slow_cw == rise_cw) && slow_frac_nz);
   assign below_fall = slow_cw < fall_cw;

   always_comb begin
      beat_next = beat;
      if (!beat && fast_gt && above_rise) begin
         beat_next = 1'b1;
      end else if (fast_lt && below_fall) begin
         beat_next = 1'b0;
      end
   end

   assign slow_out_cw = fast_gt ? fast_cw : slow_cw;

   assign decision.beat       = beat_next;
   assign decision.raise      = fast_gt;
   assign decision.fast_level = (fast_cw > CW'(LEVEL_MAX)) ? LEVEL_MAX : LEVEL_BITS'(fast_cw);
   assign decision.slow_level = (slow_out_cw > CW'(LEVEL_MAX)) ? LEVEL_MAX
                                                               : LEVEL_BITS'(slow_out_cw);

endmodule

`default_nettype wire

@@ hw/rtl/envelope_beat_detector.sv @@
// Top level of the envelope beat detector
// Usage:
//   req_bus carries one signed sample per word with a last_in_block mark.
//   Every sample updates a slow and a fast envelope (16.16 fixed point).
//   Only a marked sample yields a word on rsp_bus: beat flag, fast level and
//   slow level (slow raised to fast when fast is higher).
//   csr_bus writes the thresholds and weights; it is always ready and should
//   only be used while no sample is in flight. Unknown indexes are dropped.
// Timing:
//   A sample is registered at acceptance and processed in the next cycle unless
//   a stalled result word holds it; the result word of a marked sample is
//   registered at that step and then offered on rsp_bus.
//   One sample per cycle is sustained unless a marked sample waits on rsp_bus;
//   the limit is the envelope loop (one multiply-add per envelope per cycle).
// Reset clears both envelopes, the beat flag and all valid state, and loads
//   the register defaults.
// While rsp_bus stalls, unmarked samples keep flowing; a marked sample waits
//   in the input register, which deasserts req_bus.ready.
`default_nettype none

module envelope_beat_detector import ebd_pkg::*; #(
   parameter int SAMPLE_BITS = 16
) (
   input  logic      clock,
   input  logic      reset,
   ebd_req_if.sink   req_bus,
   ebd_rsp_if.source rsp_bus,
   ebd_csr_if.sink   csr_bus
);

   localparam int LW = SAMPLE_BITS + FRAC_BITS;

   logic [CFG_BITS-1:0] rise_threshold_ff, rise_threshold_in;
   logic [CFG_BITS-1:0] fall_threshold_ff, fall_threshold_in;
   logic [CFG_BITS-1:0] slow_weight_ff, slow_weight_in;
   logic [CFG_BITS-1:0] fast_weight_ff, fast_weight_in;

   logic                   in_valid_ff, in_valid_in;
   logic [SAMPLE_BITS-1:0] in_sample_ff, in_sample_in;
   logic                   in_last_ff, in_last_in;

   logic [LW-1:0] slow_env_ff, slow_env_in;
   logic [LW-1:0] fast_env_ff, fast_env_in;
   logic          beat_ff, beat_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_beat_ff, rsp_beat_in;
   logic [LEVEL_BITS-1:0] rsp_fast_ff, rsp_fast_in;
   logic [LEVEL_BITS-1:0] rsp_slow_ff, rsp_slow_in;

   logic                   req_take;
   logic                   core_take;
   logic [SAMPLE_BITS-1:0] mag;
   logic [LW-1:0]          target;
   logic [LW-1:0]          slow_next;
   logic [LW-1:0]          fast_next;
   decision_type           decision;

   // register writes
   assign csr_bus.ready = 1'b1;

   always_comb begin
      rise_threshold_in = rise_threshold_ff;
      fall_threshold_in = fall_threshold_ff;
      slow_weight_in    = slow_weight_ff;
      fast_weight_in    = fast_weight_ff;
      if (csr_bus.valid) begin
         case (csr_bus.index)
            CSR_RISE_THRESHOLD: rise_threshold_in = csr_bus.data;
            CSR_FALL_THRESHOLD: fall_threshold_in = csr_bus.data;
            CSR_SLOW_WEIGHT:    slow_weight_in    = csr_bus.data;
            CSR_FAST_WEIGHT:    fast_weight_in    = csr_bus.data;
            default: ;
         endcase
      end
   end

   // input register: a marked sample moves on only when the result slot frees
   assign core_take     = in_valid_ff && (!in_last_ff || !rsp_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !in_valid_ff || core_take;
   assign req_take      = req_bus.valid && req_bus.ready;

   assign in_valid_in  = req_take ? 1'b1 : (core_take ? 1'b0 : in_valid_ff);
   assign in_sample_in = req_take ? SAMPLE_BITS'(req_bus.sample) : in_sample_ff;
   assign in_last_in   = req_take ? req_bus.last_in_block : in_last_ff;

   // magnitude; the most negative code maps onto itself, i.e. 2^(SAMPLE_BITS-1)
   assign mag    = in_sample_ff[SAMPLE_BITS-1] ? SAMPLE_BITS'(~in_sample_ff + 1'b1)
                                               : in_sample_ff;
   assign target = {mag, {FRAC_BITS{1'b0}}};

   ebd_follower #(.LW(LW)) u_slow (
      .level      (slow_env_ff),
      .target     (target),
      .weight     (slow_weight_ff),
      .level_next (slow_next)
   );

   ebd_follower #(.LW(LW)) u_fast (
      .level      (fast_env_ff),
      .target     (target),
      .weight     (fast_weight_ff),
      .level_next (fast_next)
   );

   ebd_decide #(.LW(LW)) u_decide (
      .beat           (beat_ff),
      .fast_env       (fast_next),
      .slow_env       (slow_next),
      .rise_threshold (rise_threshold_ff),
      .fall_threshold (fall_threshold_ff),
      .decision       (decision)
   );

   always_comb begin
      slow_env_in  = slow_env_ff;
      fast_env_in  = fast_env_ff;
      beat_in      = beat_ff;
      rsp_beat_in  = rsp_beat_ff;
      rsp_fast_in  = rsp_fast_ff;
      rsp_slow_in  = rsp_slow_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      if (core_take) begin
         fast_env_in = fast_next;
         slow_env_in = slow_next;
         if (in_last_ff) begin
            beat_in      = decision.beat;
            slow_env_in  = decision.raise ? fast_next : slow_next;
            rsp_valid_in = 1'b1;
            rsp_beat_in  = decision.beat;
            rsp_fast_in  = decision.fast_level;
            rsp_slow_in  = decision.slow_level;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rise_threshold_ff <= RISE_THRESHOLD_RESET;
         fall_threshold_ff <= FALL_THRESHOLD_RESET;
         slow_weight_ff    <= SLOW_WEIGHT_RESET;
         fast_weight_ff    <= FAST_WEIGHT_RESET;
         in_valid_ff       <= 1'b0;
         slow_env_ff       <= '0;
         fast_env_ff       <= '0;
         beat_ff           <= 1'b0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         rise_threshold_ff <= rise_threshold_in;
         fall_threshold_ff <= fall_threshold_in;
         slow_weight_ff    <= slow_weight_in;
         fast_weight_ff    <= fast_weight_in;
         in_valid_ff       <= in_valid_in;
         slow_env_ff       <= slow_env_in;
         fast_env_ff       <= fast_env_in;
         beat_ff           <= beat_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_sample_ff <= in_sample_in;
      in_last_ff   <= in_last_in;
      rsp_beat_ff  <= rsp_beat_in;
      rsp_fast_ff  <= rsp_fast_in;
      rsp_slow_ff  <= rsp_slow_in;
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.beat       = rsp_beat_ff;
   assign rsp_bus.fast_level = rsp_fast_ff;
   assign rsp_bus.slow_level = rsp_slow_ff;

endmodule

`default_nettype wire

@@ hw/rtl/ebd_checker.sv @@
// Port-level checker of the envelope beat detector and its bind
`default_nettype none

`include "envelope_beat_detector_assert.svh"

module ebd_checker import ebd_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input logic                  req_last_in_block,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic [LEVEL_BITS-1:0] rsp_fast_level,
   input logic [LEVEL_BITS-1:0] rsp_slow_level
);

   `EBD_ASSERT_NEXT_ALWAYS(a_reset_clears, clock, reset, !rsp_valid, "result word valid after reset")
   `EBD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "result word dropped while stalled")
   `EBD_ASSERT_IMPL(a_rsp_source, clock, reset, $rose(rsp_valid), $past(req_valid && req_ready && req_last_in_block, 2), "result word without a marked sample")
   `EBD_ASSERT_IMPL(a_slow_ge_fast, clock, reset, rsp_valid, rsp_slow_level >= rsp_fast_level, "slow level below fast level")

endmodule

bind envelope_beat_detector ebd_checker u_ebd_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_bus.valid),
   .req_ready         (req_bus.ready),
   .req_last_in_block (req_bus.last_in_block),
   .rsp_valid         (rsp_bus.valid),
   .rsp_ready         (rsp_bus.ready),
   .rsp_fast_level    (rsp_bus.fast_level),
   .rsp_slow_level    (rsp_bus.slow_level)
);

`default_nettype wire

@@ tb/testbench.sv @@
// Self-checking testbench for the envelope beat detector: directed and random sample blocks
`default_nettype none

module testbench import ebd_pkg::*; ();

   localparam int LIMIT_CYCLES  = 400000;
   localparam int SETTLE_CYCLES = 4;
   localparam int HOLDOFF_LEN   = 400;

   typedef struct {
      logic                  beat;
      logic [LEVEL_BITS-1:0] fast_level;
      logic [LEVEL_BITS-1:0] slow_level;
   } beat_report_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   ebd_req_if #(.SAMPLE_BITS(16)) req_bus ();
   ebd_rsp_if                     rsp_bus ();
   ebd_csr_if                     csr_bus ();

   envelope_beat_detector #(.SAMPLE_BITS(16)) dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   always #5 clock = ~clock;

   // envelope model state
   logic [63:0]         slow_env_q;
   logic [63:0]         fast_env_q;
   logic                beat_q;
   logic [CFG_BITS-1:0] rise_thr;
   logic [CFG_BITS-1:0] fall_thr;
   logic [CFG_BITS-1:0] slow_wt;
   logic [CFG_BITS-1:0] fast_wt;

   beat_report_type pending_reports[$];

   int cycle_count    = 0;
   int mismatch_count = 0;
   int burst_left     = 0;

   // receiver control
   int hold_reqs  = 0;
   int hold_seen  = 0;
   int hold_left  = 0;
   int stall_mode = 0;
   int mode_left  = 0;
   logic [7:0] ready_pattern = 8'hFF;

   initial begin
      req_bus.valid         = 1'b0;
      req_bus.sample        = '0;
      req_bus.last_in_block = 1'b0;
      rsp_bus.ready         = 1'b0;
      csr_bus.valid         = 1'b0;
      csr_bus.index         = '0;
      csr_bus.data          = '0;
   end

   function automatic logic [63:0] follow_level(logic [63:0] level, logic [63:0] target,
                                                logic [CFG_BITS-1:0] wt);
      logic [63:0] w64;
      w64 = {48'd0, wt};
      if (target >= level)
         return level + (((target - level) * w64) >> FRAC_BITS);
      // negative step rounds towards minus infinity
      return level - ((((level - target) * w64) + 64'd65535) >> FRAC_BITS);
   endfunction

   function automatic logic [LEVEL_BITS-1:0] level_int(logic [63:0] level);
      logic [63:0] v;
      v = level >> FRAC_BITS;
      return (v > 64'd65535) ? LEVEL_MAX : v[LEVEL_BITS-1:0];
   endfunction

   function automatic void track_envelopes(logic signed [15:0] s, logic mark);
      logic [16:0]     mag;
      logic [63:0]     target;
      beat_report_type rpt;
      mag    = s[15] ? (~{s[15], s} + 17'd1) : {1'b0, s};
      target = {31'd0, mag, 16'd0};
      slow_env_q = follow_level(slow_env_q, target, slow_wt);
      fast_env_q = follow_level(fast_env_q, target, fast_wt);
      if (mark) begin
         if (!beat_q && fast_env_q > slow_env_q && slow_env_q > ({48'd0, rise_thr} << FRAC_BITS))
            beat_q = 1'b1;
         else if (fast_env_q < slow_env_q && slow_env_q < ({48'd0, fall_thr} << FRAC_BITS))
            beat_q = 1'b0;
         if (fast_env_q > slow_env_q)
            slow_env_q = fast_env_q;
         rpt.beat       = beat_q;
         rpt.fast_level = level_int(fast_env_q);
         rpt.slow_level = level_int(slow_env_q);
         pending_reports.push_back(rpt);
      end
   endfunction

   function automatic void apply_reg(logic [CSR_IDX_BITS-1:0] idx, logic [CFG_BITS-1:0] val);
      case (idx)
         CSR_RISE_THRESHOLD: rise_thr = val;
         CSR_FALL_THRESHOLD: fall_thr = val;
         CSR_SLOW_WEIGHT:    slow_wt  = val;
         CSR_FAST_WEIGHT:    fast_wt  = val;
         default: ;
      endcase
   endfunction

   // ---------------------------------------------------------------- drivers

   task automatic send_word(logic signed [15:0] s, logic mark);
      @(negedge clock);
      if (burst_left == 0) begin
         req_bus.valid = 1'b0;
         repeat ($urandom_range(1, 8)) @(negedge clock);
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(150, 400)
                                                  : $urandom_range(1, 12);
      end
      req_bus.valid         = 1'b1;
      req_bus.sample        = s;
      req_bus.last_in_block = mark;
      forever begin
         @(posedge clock);
         if (req_bus.ready) break;
      end
      track_envelopes(s, mark);
      burst_left--;
   endtask

   task automatic write_reg(logic [CSR_IDX_BITS-1:0] idx, logic [CFG_BITS-1:0] val);
      @(negedge clock);
      csr_bus.valid = 1'b1;
      csr_bus.index = idx;
      csr_bus.data  = val;
      forever begin
         @(posedge clock);
         if (csr_bus.ready) break;
      end
      apply_reg(idx, val);
      @(negedge clock);
      csr_bus.valid = 1'b0;
   endtask

   task automatic write_all(logic [CFG_BITS-1:0] rise, logic [CFG_BITS-1:0] fall,
                            logic [CFG_BITS-1:0] sw, logic [CFG_BITS-1:0] fw);
      write_reg(CSR_RISE_THRESHOLD, rise);
      write_reg(CSR_FALL_THRESHOLD, fall);
      write_reg(CSR_SLOW_WEIGHT, sw);
      write_reg(CSR_FAST_WEIGHT, fw);
   endtask

   // sender stops, all results back, then unmarked words get time to retire
   task automatic drain_pipeline();
      @(negedge clock);
      req_bus.valid = 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // receiver: stall pattern of its own, plus long hold-offs on request
   always @(negedge clock) begin
      if (hold_reqs != hold_seen) begin
         hold_seen = hold_reqs;
         hold_left = HOLDOFF_LEN;
      end
      if (mode_left == 0) begin
         stall_mode    = $urandom_range(0, 3);
         mode_left     = $urandom_range(32, 300);
         ready_pattern = 8'($urandom);
      end else begin
         mode_left--;
      end
      ready_pattern = {ready_pattern[6:0], ready_pattern[7]};
      if (hold_left > 0) begin
         hold_left--;
         rsp_bus.ready = 1'b0;
      end else begin
         case (stall_mode)
            0:       rsp_bus.ready = 1'b1;
            1:       rsp_bus.ready = 1'($urandom_range(0, 1));
            2:       rsp_bus.ready = ($urandom_range(0, 3) == 0);
            default: rsp_bus.ready = ready_pattern[0];
         endcase
      end
   end

   // result checker
   always @(posedge clock) begin : check_result
      beat_report_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_reports.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected word: beat=%0d fast=%0d slow=%0d",
                        rsp_bus.beat, rsp_bus.fast_level, rsp_bus.slow_level);
         end else begin
            want = pending_reports.pop_front();
            if (rsp_bus.beat !== want.beat || rsp_bus.fast_level !== want.fast_level ||
                rsp_bus.slow_level !== want.slow_level) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch: beat %0d/%0d fast %0d/%0d slow %0d/%0d (exp/got)",
                           want.beat, rsp_bus.beat, want.fast_level, rsp_bus.fast_level,
                           want.slow_level, rsp_bus.slow_level);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("[envelope_beat_detector] ERROR");
         $finish;
      end
   end

   // ------------------------------------------------------------------ tests

   task automatic test_default_extremes();
      send_word(16'sd32767, 1'b0);
      send_word(-16'sd32768, 1'b1);
      send_word(16'sd0, 1'b1);
      send_word(-16'sd1, 1'b0);
      send_word(16'sd1, 1'b1);
      send_word(16'sh5555, 1'b1);
   endtask

   task automatic test_register_writes();
      drain_pipeline();
      // out-of-range indexes must be dropped
      write_reg(CSR_IDX_BITS'(4), CFG_BITS'($urandom));
      write_reg(CSR_IDX_BITS'(8), CFG_BITS'($urandom));
      write_reg(CSR_IDX_BITS'(15), CFG_BITS'($urandom));
      // zero weights freeze both levels
      write_all(16'd0, 16'd0, 16'd0, 16'd0);
      send_word(-16'sd32768, 1'b1);
      send_word(16'sd12345, 1'b1);
      drain_pipeline();
      write_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_word(-16'sd32768, 1'b1);
      send_word(16'sd0, 1'b1);
      drain_pipeline();
      write_all(16'hFFFF, 16'd0, 16'hFFFF, 16'd0);
      send_word(16'sd32767, 1'b1);
   endtask

   task automatic test_beat_hysteresis();
      drain_pipeline();
      write_all(16'd100, 16'd50, 16'd32768, 16'd65535);
      send_word(16'sd1000, 1'b1);     // slow still above fast; beat sets on the next word
      send_word(16'sd20000, 1'b1);
      repeat (5) send_word(16'sd0, 1'b1);  // slow decays, still above the fall threshold
      send_word(-16'sd30000, 1'b1);
   endtask

   task automatic test_receiver_holdoff();
      int n;
      drain_pipeline();
      write_all(16'd200, 16'd100, 16'd2000, 16'd30000);
      hold_reqs++;
      for (n = 0; n < 80; n++)
         send_word(16'($urandom), (n % 3) == 2);
      drain_pipeline();
   endtask

   task automatic send_block(int len, logic mark_end);
      int amp;
      int k;
      int v;
      case ($urandom_range(0, 3))
         0:       amp = 64;
         1:       amp = 1024;
         2:       amp = 8192;
         default: amp = 32767;
      endcase
      for (k = 0; k < len; k++) begin
         if ($urandom_range(0, 32) == 0)
            v = $urandom_range(0, 1) ? 32767 : -32768;
         else
            v = $urandom_range(0, 2 * amp) - amp;
         send_word(16'(v), mark_end && (k == len - 1));
      end
   endtask

   task automatic test_random_blocks(int total);
      int phase;
      int sent;
      int len;
      int budget;
      logic [CFG_BITS-1:0] rise;
      budget = total / 8;
      for (phase = 0; phase < 8; phase++) begin
         drain_pipeline();
         case (phase)
            0: write_all(16'd0, 16'd0, 16'd0, 16'd0);
            1: write_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
            2: write_all(RISE_THRESHOLD_RESET, FALL_THRESHOLD_RESET,
                         SLOW_WEIGHT_RESET, FAST_WEIGHT_RESET);
            default: begin
               rise = CFG_BITS'($urandom_range(0, 3000));
               write_all(rise, CFG_BITS'($urandom_range(0, 1) ? $urandom_range(0, rise)
                                                              : $urandom_range(0, 65535)),
                         CFG_BITS'($urandom_range(1, 8000)),
                         CFG_BITS'($urandom_range(8000, 65535)));
               if ($urandom_range(0, 1))
                  write_reg(CSR_IDX_BITS'($urandom_range(4, 15)), CFG_BITS'($urandom));
            end
         endcase
         sent = 0;
         while (sent < budget) begin
            case ($urandom_range(0, 19))
               0:          len = 1;
               1, 2, 3, 4: len = $urandom_range(13, 40);
               default:    len = $urandom_range(1, 12);
            endcase
            // a few blocks lose their end mark and run into the next one
            send_block(len, $urandom_range(0, 9) != 0);
            sent += len;
         end
      end
   endtask

   initial begin
      slow_env_q = '0;
      fast_env_q = '0;
      beat_q     = 1'b0;
      rise_thr   = RISE_THRESHOLD_RESET;
      fall_thr   = FALL_THRESHOLD_RESET;
      slow_wt    = SLOW_WEIGHT_RESET;
      fast_wt    = FAST_WEIGHT_RESET;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_default_extremes();
      test_register_writes();
      test_beat_hysteresis();
      test_receiver_holdoff();
      test_random_blocks(1600);
      drain_pipeline();
      repeat (8) @(posedge clock);

      if (mismatch_count == 0 && pending_reports.size() == 0)
         $display("[envelope_beat_detector] OK");
      else
         $display("[envelope_beat_detector] ERROR");
      $finish;
   end

endmodule

`default_nettype wire
